// ===== design/iee_pkg.sv =====
// Shared types and codes for the infix expression evaluator.
// Depends on nothing; the front, queue, back and arithmetic unit use it.
package iee_pkg;

	// Token classes produced by the front end.
	localparam logic [1:0] TK_DIGIT = 2'd0;
	localparam logic [1:0] TK_OP    = 2'd1;
	localparam logic [1:0] TK_SPACE = 2'd2;
	localparam logic [1:0] TK_BAD   = 2'd3;

	// Operator codes; bit 1 set means multiply or divide, the higher precedence.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	// Kind of the last token seen.
	localparam logic [1:0] LK_NONE     = 2'd0;
	localparam logic [1:0] LK_NUMBER   = 2'd1;
	localparam logic [1:0] LK_OPERATOR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] digit;
		logic [1:0] op;
		logic       last;
	} token_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} alu_cmd_t;

endpackage

// ===== design/iee_front.sv =====
// Front end: takes characters and classifies them into tokens.
// Depends on iee_pkg; feeds the token queue.
module iee_front (
	input  logic           char_valid,
	output logic           char_ready,
	input  logic [7:0]     char_code,
	input  logic           end_of_expr,
	input  logic           queue_full,
	output logic           push,
	output iee_pkg::token_t tok
);

	always_comb begin
		tok.kind  = iee_pkg::TK_BAD;
		tok.digit = char_code[3:0];
		tok.op    = iee_pkg::OP_ADD;
		tok.last  = end_of_expr;
		if (char_code == 8'd32 || (char_code >= 8'd9 && char_code <= 8'd13)) begin
			tok.kind = iee_pkg::TK_SPACE;
		end else if (char_code >= 8'd48 && char_code <= 8'd57) begin
			tok.kind = iee_pkg::TK_DIGIT;
		end else if (char_code == 8'd43) begin
			tok.kind = iee_pkg::TK_OP;
			tok.op   = iee_pkg::OP_ADD;
		end else if (char_code == 8'd45) begin
			tok.kind = iee_pkg::TK_OP;
			tok.op   = iee_pkg::OP_SUB;
		end else if (char_code == 8'd42) begin
			tok.kind = iee_pkg::TK_OP;
			tok.op   = iee_pkg::OP_MUL;
		end else if (char_code == 8'd47) begin
			tok.kind = iee_pkg::TK_OP;
			tok.op   = iee_pkg::OP_DIV;
		end
	end

	assign char_ready = !queue_full;
	assign push       = char_valid && !queue_full;

endmodule

// ===== design/iee_queue.sv =====
// Two-entry token queue between the front end and the back end.
// Depends on iee_pkg for the token type.
module iee_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  iee_pkg::token_t push_tok,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output iee_pkg::token_t head
);

	iee_pkg::token_t mem_q [0:1];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_tok;
		end
	end

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rptr_q];

endmodule

// ===== design/iee_alu.sv =====
// Iterative multiply and divide unit, one bit per cycle.
// Depends on iee_pkg for the command struct; used by the back end.
module iee_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iee_pkg::alu_cmd_t     cmd,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int CW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] p_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH:0]   r_q;
	logic                  div_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;

	assign mag_a   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
	assign shifted = {r_q[DATA_WIDTH-1:0], p_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q <= cmd.is_div;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			r_q   <= '0;
			p_q   <= cmd.is_div ? mag_a : b;
			d_q   <= cmd.is_div ? mag_b : a;
		end else if (busy_q) begin
			if (div_q) begin
				// Restoring division on magnitudes; the quotient shifts into p.
				if (!diff[DATA_WIDTH]) begin
					r_q <= diff;
					p_q <= {p_q[DATA_WIDTH-2:0], 1'b1};
				end else begin
					r_q <= shifted;
					p_q <= {p_q[DATA_WIDTH-2:0], 1'b0};
				end
			end else begin
				// Shift-and-add product, kept modulo the data width.
				if (p_q[0]) begin
					r_q <= {1'b0, r_q[DATA_WIDTH-1:0] + d_q};
				end
				d_q <= d_q << 1;
				p_q <= p_q >> 1;
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? (~p_q + 1'b1) : p_q) : r_q[DATA_WIDTH-1:0];

endmodule

// ===== design/iee_back.sv =====
// Back end: number accumulation, value and operator stacks, reductions.
// Depends on iee_pkg and iee_alu; drives the result register.
module iee_back #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_avail,
	input  iee_pkg::token_t       tok,
	output logic                  tok_pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [DATA_WIDTH-1:0] result_value,
	output logic [1:0]            result_status
);

	localparam logic [2:0] S_TAKE   = 3'd0;
	localparam logic [2:0] S_OPRED  = 3'd1;
	localparam logic [2:0] S_END    = 3'd2;
	localparam logic [2:0] S_ENDRED = 3'd3;
	localparam logic [2:0] S_RED    = 3'd4;
	localparam logic [2:0] S_WAIT   = 3'd5;

	logic [2:0]            state_q;
	logic [2:0]            ret_q;
	logic [DATA_WIDTH-1:0] vals_q [0:2];
	logic [1:0]            vcnt_q;
	logic [1:0]            ops_q [0:1];
	logic [1:0]            ocnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  innum_q;
	logic [1:0]            lastk_q;
	logic                  sawop_q;
	logic [1:0]            err_q;
	logic [1:0]            pop_q;
	logic                  plast_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic [1:0]            out_status_q;

	logic [1:0]            vcnt_m1;
	logic [1:0]            vcnt_m2;
	logic [1:0]            ocnt_m1;
	logic [1:0]            top_op;
	logic [DATA_WIDTH-1:0] opa;
	logic [DATA_WIDTH-1:0] opb;
	logic                  out_free;
	logic                  alu_done;
	logic [DATA_WIDTH-1:0] alu_result;
	iee_pkg::alu_cmd_t     alu_cmd;

	assign vcnt_m1  = vcnt_q - 2'd1;
	assign vcnt_m2  = vcnt_q - 2'd2;
	assign ocnt_m1  = ocnt_q - 2'd1;
	assign top_op   = ops_q[ocnt_m1[0]];
	assign opb      = vals_q[vcnt_m1];
	assign opa      = vals_q[vcnt_m2];
	assign out_free = !out_valid_q || result_ready;
	assign tok_pop  = (state_q == S_TAKE) && tok_avail;

	always_comb begin
		alu_cmd.start  = 1'b0;
		alu_cmd.is_div = top_op == iee_pkg::OP_DIV;
		if (state_q == S_RED && vcnt_q >= 2'd2 && ocnt_q != 2'd0) begin
			if (top_op == iee_pkg::OP_MUL) begin
				alu_cmd.start = 1'b1;
			end else if (top_op == iee_pkg::OP_DIV && opb != '0) begin
				alu_cmd.start = 1'b1;
			end
		end
	end

	iee_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.a      (opa),
		.b      (opb),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TAKE;
			ret_q       <= S_TAKE;
			vcnt_q      <= 2'd0;
			ocnt_q      <= 2'd0;
			acc_q       <= '0;
			innum_q     <= 1'b0;
			lastk_q     <= iee_pkg::LK_NONE;
			sawop_q     <= 1'b0;
			err_q       <= iee_pkg::ST_OK;
			pop_q       <= iee_pkg::OP_ADD;
			plast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_TAKE: begin
					if (tok_avail) begin
						plast_q <= tok.last;
						pop_q   <= tok.op;
						if (tok.last) begin
							state_q <= S_END;
						end
						if (err_q == iee_pkg::ST_OK) begin
							unique case (tok.kind)
								iee_pkg::TK_SPACE: begin
									if (innum_q) begin
										if (vcnt_q == 2'd3) begin
											err_q <= iee_pkg::ST_INVALID;
										end else begin
											vcnt_q <= vcnt_q + 2'd1;
										end
										innum_q <= 1'b0;
										acc_q   <= '0;
									end
								end
								iee_pkg::TK_DIGIT: begin
									if (!innum_q) begin
										if (lastk_q == iee_pkg::LK_NUMBER) begin
											err_q <= iee_pkg::ST_INVALID;
										end else begin
											innum_q <= 1'b1;
											lastk_q <= iee_pkg::LK_NUMBER;
											acc_q   <= DATA_WIDTH'(tok.digit);
										end
									end else begin
										acc_q <= (acc_q << 3) + (acc_q << 1) +
											DATA_WIDTH'(tok.digit);
									end
								end
								iee_pkg::TK_OP: begin
									if (innum_q) begin
										if (vcnt_q == 2'd3) begin
											err_q <= iee_pkg::ST_INVALID;
										end else begin
											vcnt_q <= vcnt_q + 2'd1;
										end
										innum_q <= 1'b0;
										acc_q   <= '0;
									end
									if (lastk_q != iee_pkg::LK_NUMBER) begin
										err_q <= iee_pkg::ST_INVALID;
									end
									sawop_q <= 1'b1;
									state_q <= S_OPRED;
								end
								default: begin
									err_q <= iee_pkg::ST_INVALID;
								end
							endcase
						end
					end
				end
				S_OPRED: begin
					if (err_q != iee_pkg::ST_OK) begin
						state_q <= plast_q ? S_END : S_TAKE;
					end else if (ocnt_q != 2'd0 && (top_op[1] || !pop_q[1])) begin
						ret_q   <= S_OPRED;
						state_q <= S_RED;
					end else begin
						if (ocnt_q == 2'd2) begin
							err_q <= iee_pkg::ST_INVALID;
						end else begin
							ops_q[ocnt_q[0]] <= pop_q;
							ocnt_q           <= ocnt_q + 2'd1;
						end
						lastk_q <= iee_pkg::LK_OPERATOR;
						state_q <= plast_q ? S_END : S_TAKE;
					end
				end
				S_END: begin
					if (err_q == iee_pkg::ST_OK) begin
						if (innum_q) begin
							if (vcnt_q == 2'd3) begin
								err_q <= iee_pkg::ST_INVALID;
							end else begin
								vcnt_q <= vcnt_q + 2'd1;
							end
						end
						if (!sawop_q) begin
							err_q <= iee_pkg::ST_INVALID;
						end
					end
					state_q <= S_ENDRED;
				end
				S_ENDRED: begin
					if (err_q == iee_pkg::ST_OK && ocnt_q != 2'd0) begin
						ret_q   <= S_ENDRED;
						state_q <= S_RED;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						if (err_q != iee_pkg::ST_OK) begin
							out_value_q  <= '0;
							out_status_q <= err_q;
						end else if (vcnt_q != 2'd0) begin
							out_value_q  <= opb;
							out_status_q <= iee_pkg::ST_OK;
						end else begin
							out_value_q  <= '0;
							out_status_q <= iee_pkg::ST_INVALID;
						end
						// The stacks, number state and error status clear after each report.
						vcnt_q  <= 2'd0;
						ocnt_q  <= 2'd0;
						acc_q   <= '0;
						innum_q <= 1'b0;
						lastk_q <= iee_pkg::LK_NONE;
						sawop_q <= 1'b0;
						err_q   <= iee_pkg::ST_OK;
						state_q <= S_TAKE;
					end
				end
				S_RED: begin
					if (vcnt_q < 2'd2 || ocnt_q == 2'd0) begin
						err_q   <= iee_pkg::ST_INVALID;
						state_q <= ret_q;
					end else begin
						ocnt_q <= ocnt_m1;
						unique case (top_op)
							iee_pkg::OP_ADD: begin
								vals_q[vcnt_m2] <= opa + opb;
								vcnt_q          <= vcnt_m1;
								state_q         <= ret_q;
							end
							iee_pkg::OP_SUB: begin
								vals_q[vcnt_m2] <= opa - opb;
								vcnt_q          <= vcnt_m1;
								state_q         <= ret_q;
							end
							iee_pkg::OP_MUL: begin
								vcnt_q  <= vcnt_m2;
								state_q <= S_WAIT;
							end
							default: begin
								vcnt_q <= vcnt_m2;
								if (opb == '0) begin
									err_q   <= iee_pkg::ST_DIVZERO;
									state_q <= ret_q;
								end else begin
									state_q <= S_WAIT;
								end
							end
						endcase
					end
				end
				S_WAIT: begin
					if (alu_done) begin
						vals_q[vcnt_q] <= alu_result;
						vcnt_q         <= vcnt_q + 2'd1;
						state_q        <= ret_q;
					end
				end
				default: begin
					state_q <= S_TAKE;
				end
			endcase
			// A finished number is written from acc_q into the next free stack slot.
			if (state_q == S_TAKE && tok_avail && err_q == iee_pkg::ST_OK &&
				tok.kind != iee_pkg::TK_DIGIT && tok.kind != iee_pkg::TK_BAD &&
				innum_q && vcnt_q != 2'd3) begin
				vals_q[vcnt_q] <= acc_q;
			end
			if (state_q == S_END && err_q == iee_pkg::ST_OK && innum_q &&
				vcnt_q != 2'd3) begin
				vals_q[vcnt_q] <= acc_q;
				innum_q        <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign result_value  = out_value_q;
	assign result_status = out_status_q;

endmodule

// ===== design/infix_expression_evaluator_unit.sv =====
// Top level of the infix expression evaluator.
// Depends on iee_pkg, iee_front, iee_queue and iee_back.
//
// Characters enter on the char channel, one per request, with end_of_expr on the
// last one; one result (value and status) leaves on the result channel per
// expression. A front end classifies characters into a two-entry token queue, so
// input is taken while the back end works. Reductions for * and / share one
// bit-serial multiply/divide unit. An operator or the end of an expression may
// trigger up to two reductions. Status 0 is ok, 1 invalid, 2 division by zero.
module infix_expression_evaluator_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         char_valid,
	output logic                         char_ready,
	input  logic [7:0]                   char_code,
	input  logic                         end_of_expr,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic [1:0]                   status
);

	iee_pkg::token_t       front_tok;
	iee_pkg::token_t       head_tok;
	logic                  push;
	logic                  full;
	logic                  pop;
	logic                  not_empty;
	logic [DATA_WIDTH-1:0] back_value;

	iee_front u_front (
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_code   (char_code),
		.end_of_expr (end_of_expr),
		.queue_full  (full),
		.push        (push),
		.tok         (front_tok)
	);

	iee_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (front_tok),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head_tok)
	);

	iee_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_avail     (not_empty),
		.tok           (head_tok),
		.tok_pop       (pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_value  (back_value),
		.result_status (status)
	);

	assign value = back_value;

endmodule
